[src/tsws_pkg.sv]
// Package for the task scheduler with semaphores: item kinds, FSM states and
// per-task record type. No dependencies.
package tsws_pkg;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_SCHED = 3'd1,
    KIND_SLEEP = 3'd2,
    KIND_P     = 3'd3,
    KIND_V     = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_LOAD,
    ST_PASS,
    ST_REFILL,
    ST_SKIP,
    ST_PASS2,
    ST_WAKE,
    ST_OUT
  } state_t;

  // One entry of the task memory.
  typedef struct packed {
    logic [7:0]  slice;
    logic [15:0] sleep;
    logic        blocked;
  } task_rec_t;

  localparam logic [16:0] SKIP_NONE = 17'h10000;

endpackage

[src/task_scheduler_with_semaphores_unit.sv]
// Top level of the task scheduler with semaphores.
// Holds the task memory, the lock and wait-ring state and the sequencer.
// Depends on tsws_pkg.
//
// Usage: one word on the in_ channel (kind, sleep_amount, lock_index) gives
// one word on the out_ channel (running_task, none_ready, woke_valid,
// woken_task). Configuration words on the cfg_ channel set task priorities
// (indexes 0..3) and initial lock counts (indexes 4..5); loading an initial
// count also loads the lock count. cfg_ready is high only while the block is
// idle. A tick, an unknown kind, a P without blocking and a V without a wake
// go straight to the result; a V that wakes a task passes through the wake
// state first. A schedule runs a first pass and, if that picks no task, a
// refill sweep, a sleep subtraction sweep and a second pass, the last two
// left out when no task can run; the memory is walked one task per cycle.
// One item is in work at a time; the next can be accepted in the cycle in
// which the result appears if out_ready is high. If the receiver stalls,
// the result holds and in_ready stays low. After reset the task memory is
// cleared by a sweep over all NUM_TASKS entries, during which in_ready and
// cfg_ready are low.
module task_scheduler_with_semaphores_unit #(
  parameter int NUM_TASKS   = 4,
  parameter int QUEUE_DEPTH = 4,
  parameter int NUM_LOCKS   = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_sleep_amount,
  input  logic        in_lock_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_running_task,
  output logic        out_none_ready,
  output logic        out_woke_valid,
  output logic [1:0]  out_woken_task,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tsws_pkg::*;

  localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int RD = NUM_LOCKS * QUEUE_DEPTH;
  localparam int RW = $clog2(RD);
  localparam int CW = TW + 1;

  // Task memory: one read port, one write port, registered read data.
  task_rec_t        tmem [NUM_TASKS];
  logic [TW-1:0]    rd_addr;
  task_rec_t        rd_data_r;
  logic             wr_en;
  logic [TW-1:0]    wr_addr;
  task_rec_t        wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tmem[wr_addr] <= wr_data;
    end
    rd_data_r <= tmem[rd_addr];
  end

  // Wait rings; entries are undefined until written.
  logic [TW-1:0] ring_mem [RD];

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r;            // sweep index, also clearing pass
  logic            clr_r;
  logic [TW-1:0]   cur_r;
  logic [7:0]      prio_r [NUM_TASKS];
  logic [7:0]      lcnt_r [NUM_LOCKS];
  logic [QW-1:0]   head_r [NUM_LOCKS];
  logic [QW-1:0]   tail_r [NUM_LOCKS];
  kind_t           kind_r;
  logic [15:0]     amt_r;
  logic [LW-1:0]   lk_r;
  logic            lk_ok_r;
  logic [7:0]      best_r;
  logic            found_r;
  logic [TW-1:0]   pick_r;
  logic [16:0]     skip_r;
  logic            sched_r, woke_r;
  logic [TW-1:0]   woken_r;
  logic [TW-1:0]   ring_rd_r;        // ring entry at the tail of the item's lock
  logic [1:0]      o_run_r, o_woken_r;
  logic            o_none_r, o_woke_r, o_valid_r;

  logic [TW-1:0]   idx;              // task being handled in a sweep
  logic [TW-1:0]   nxt_idx;
  logic            last;
  logic            pass_hit;
  logic [LW-1:0]   lsel;
  logic [7:0]      lc_dec, lc_inc;
  logic            go_sched, go_wake;
  logic [LW-1:0]   in_lk;
  logic [RW-1:0]   head_idx, in_tail_idx;

  assign idx     = cnt_r[TW-1:0];
  assign last    = (cnt_r == CW'(NUM_TASKS - 1));
  assign nxt_idx = last ? '0 : idx + TW'(1);
  assign lsel    = lk_r;
  assign lc_dec  = (lcnt_r[lsel] == 8'h80) ? lcnt_r[lsel] : lcnt_r[lsel] - 8'd1;
  assign lc_inc  = (lcnt_r[lsel] == 8'h7f) ? lcnt_r[lsel] : lcnt_r[lsel] + 8'd1;

  // A schedule follows sleep and schedule words, and a P whose count went
  // negative. A V wakes the oldest waiter when its count is zero or below.
  assign go_sched = (kind_r inside {KIND_SCHED, KIND_SLEEP}) ||
                    (kind_r == KIND_P && lk_ok_r && lc_dec[7]);
  assign go_wake  = (kind_r == KIND_V) && lk_ok_r && (lc_inc[7] || lc_inc == 8'd0);

  assign in_lk       = LW'(in_lock_index);
  assign head_idx    = RW'(32'(lsel) * QUEUE_DEPTH + 32'(head_r[lsel]));
  assign in_tail_idx = RW'(32'(in_lk) * QUEUE_DEPTH + 32'(tail_r[in_lk]));

  assign in_ready  = (state_r == ST_IDLE) && !clr_r && !(o_valid_r && !out_ready);
  assign cfg_ready = (state_r == ST_IDLE) && !clr_r;
  assign out_valid        = o_valid_r;
  assign out_running_task = o_run_r;
  assign out_none_ready   = o_none_r;
  assign out_woke_valid   = o_woke_r;
  assign out_woken_task   = o_woken_r;

  // Pass test on the record just read.
  assign pass_hit = (rd_data_r.slice > best_r) && (rd_data_r.sleep == '0)
                    && !rd_data_r.blocked;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid && in_ready) state_nxt = ST_RD;
      ST_RD: begin
        if (go_sched) begin
          state_nxt = ST_LOAD;
        end else if (go_wake) begin
          state_nxt = ST_WAKE;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_LOAD:   state_nxt = ST_PASS;
      ST_PASS:   if (last) state_nxt = found_r || pass_hit ? ST_OUT : ST_REFILL;
      ST_REFILL: if (last) state_nxt = ST_SKIP;
      ST_SKIP: begin
        // No task that could ever run: leave the state as after the refill.
        if (skip_r == SKIP_NONE) state_nxt = ST_OUT;
        else if (last) state_nxt = ST_PASS2;
      end
      ST_PASS2:  if (last) state_nxt = ST_OUT;
      ST_WAKE:   state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Memory port control. In a sweep the record of idx is in rd_data_r, the
  // next one is requested and the modified record is written back.
  always_comb begin
    task_rec_t r;
    logic [15:0] s;
    r = rd_data_r;
    s = 16'd0;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data_r;
    rd_addr = idx;
    if (clr_r) begin
      wr_en   = 1'b1;
      wr_data = '0;
    end
    case (state_r)
      ST_IDLE: rd_addr = cur_r;
      ST_RD: begin
        wr_addr = cur_r;
        rd_addr = ring_rd_r;
        if (kind_r == KIND_TICK) begin
          wr_en = 1'b1;
          if (r.slice != 8'd0) r.slice = r.slice - 8'd1;
        end else if (kind_r == KIND_SLEEP) begin
          wr_en = 1'b1;
          r.sleep = amt_r;
        end else if (kind_r == KIND_P && lk_ok_r && lc_dec[7]) begin
          wr_en = 1'b1;
          r.blocked = 1'b1;
        end
        wr_data = r;
      end
      // The write of the running task lands before task 0 is read here.
      ST_LOAD: rd_addr = '0;
      ST_PASS, ST_PASS2: begin
        rd_addr = nxt_idx;
        if (!pass_hit && r.sleep != 16'd0) begin
          wr_en = 1'b1;
          r.sleep = r.sleep - 16'd1;
        end
        wr_data = r;
      end
      ST_REFILL: begin
        rd_addr = nxt_idx;
        wr_en   = 1'b1;
        r.slice = prio_r[idx];
        wr_data = r;
      end
      ST_SKIP: begin
        rd_addr = nxt_idx;
        if (skip_r != SKIP_NONE) begin
          s = skip_r[15:0];
          wr_en = 1'b1;
          r.sleep = (r.sleep > s) ? r.sleep - s : 16'd0;
          wr_data = r;
        end
      end
      ST_WAKE: begin
        wr_addr   = woken_r;
        wr_en     = 1'b1;
        r.blocked = 1'b0;
        wr_data   = r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    logic [16:0] cand;
    cand = {1'b0, rd_data_r.sleep};
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      clr_r     <= 1'b1;
      cnt_r     <= '0;
      cur_r     <= '0;
      o_valid_r <= 1'b0;
      for (int t = 0; t < NUM_TASKS; t++) prio_r[t] <= 8'd1;
      for (int l = 0; l < NUM_LOCKS; l++) begin
        lcnt_r[l] <= 8'd1;
        head_r[l] <= '0;
        tail_r[l] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT) o_valid_r <= 1'b1;
      else if (out_ready) o_valid_r <= 1'b0;
      if (clr_r) begin
        cnt_r <= last ? '0 : cnt_r + CW'(1);
        if (last) clr_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            if (32'(cfg_index) < NUM_TASKS && cfg_index < 3'd4) begin
              prio_r[cfg_index[TW-1:0]] <= cfg_data;
            end else if (cfg_index == 3'd4 || cfg_index == 3'd5) begin
              if (32'(cfg_index - 3'd4) < NUM_LOCKS)
                lcnt_r[LW'(cfg_index - 3'd4)] <= {4'd0, cfg_data[3:0]};
            end
          end
          if (in_valid && in_ready) begin
            kind_r    <= kind_t'(in_kind);
            amt_r     <= in_sleep_amount;
            lk_r      <= in_lk;
            lk_ok_r   <= (32'(in_lock_index) < NUM_LOCKS);
            ring_rd_r <= ring_mem[in_tail_idx];
            cnt_r     <= '0;
            best_r    <= '0;
            found_r   <= 1'b0;
            skip_r    <= SKIP_NONE;
          end
        end
        ST_RD: begin
          sched_r <= go_sched;
          woke_r  <= go_wake;
          woken_r <= go_wake ? ring_rd_r : '0;
          if (kind_r == KIND_P && lk_ok_r) begin
            lcnt_r[lsel] <= lc_dec;
            if (lc_dec[7]) begin
              ring_mem[head_idx] <= cur_r;
              head_r[lsel] <= (head_r[lsel] == QW'(QUEUE_DEPTH - 1)) ? '0 :
                              head_r[lsel] + QW'(1);
            end
          end else if (kind_r == KIND_V && lk_ok_r) begin
            lcnt_r[lsel] <= lc_inc;
            if (go_wake) begin
              tail_r[lsel] <= (tail_r[lsel] == QW'(QUEUE_DEPTH - 1)) ? '0 :
                              tail_r[lsel] + QW'(1);
            end
          end
        end
        ST_PASS, ST_PASS2: begin
          if (pass_hit) begin
            best_r  <= rd_data_r.slice;
            pick_r  <= idx;
            found_r <= 1'b1;
          end
          cnt_r <= last ? '0 : cnt_r + CW'(1);
        end
        ST_REFILL: begin
          // Smallest sleep count among the tasks that could run at all.
          if (!rd_data_r.blocked && prio_r[idx] != 8'd0 && cand < skip_r)
            skip_r <= cand;
          cnt_r <= last ? '0 : cnt_r + CW'(1);
        end
        ST_SKIP: cnt_r <= last ? '0 : cnt_r + CW'(1);
        ST_OUT: begin
          if (found_r) cur_r <= pick_r;
          o_run_r   <= 2'(found_r ? pick_r : cur_r);
          o_none_r  <= sched_r && !found_r;
          o_woke_r  <= woke_r;
          o_woken_r <= 2'(woken_r);
        end
        default: ;
      endcase
    end
  end
endmodule

[tb/task_scheduler_with_semaphores_unit_tb.sv]
// Self-checking testbench for task_scheduler_with_semaphores_unit: a directed
// table and then random phases, each result checked against a hand-typed
// word or a built-in scheduler predictor. Depends on tsws_pkg and the unit under test.
module task_scheduler_with_semaphores_unit_tb;
  import tsws_pkg::*;

  // Kinds that the block must ignore, and the register map of the cfg_ channel.
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam logic [2:0] REG_PRIO0      = 3'd0;
  localparam logic [2:0] REG_INIT0      = 3'd4;
  localparam logic [2:0] REG_SPARE      = 3'd6;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         PHASES         = 8;
  localparam int         ITEMS_PER_PHASE = 205;

  // One result word, in the order of the out_ ports.
  typedef struct packed {
    logic [1:0] run;
    logic       none;
    logic       woke;
    logic [1:0] who;
  } sched_result_t;

  // One row of the directed table. Where known_result is set, the row carries
  // an expected word typed in by hand; otherwise the predictor supplies it.
  typedef struct {
    logic [2:0]    kind;
    logic [15:0]   amount;
    logic          lock;
    bit            known_result;
    sched_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [2:0]  in_kind;
  logic [15:0] in_sleep_amount;
  logic        in_lock_index;
  logic        out_valid, out_ready;
  logic [1:0]  out_running_task;
  logic        out_none_ready, out_woke_valid;
  logic [1:0]  out_woken_task;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  task_scheduler_with_semaphores_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: the registers, the task table, the locks and their rings.
  logic [7:0]  prio_reg [4];
  logic [3:0]  init_reg [2];
  logic [1:0]  cur_task;
  logic [7:0]  slice_cnt [4];
  logic [15:0] sleep_cnt [4];
  bit          blocked [4];
  int          lock_cnt [2];
  logic [1:0]  ring [8];
  bit          ring_written [8];
  logic [1:0]  ring_head [2];
  logic [1:0]  ring_tail [2];

  sched_result_t expected_q [$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  stim_row_t table_rows [$];

  // One scheduling pass: the awake, unblocked task with the largest slice
  // wins, lowest index on a tie. Sleepers the pass walks over lose one count.
  function automatic int pass_once();
    int pick;
    int best;
    pick = -1;
    best = 0;
    for (int t = 0; t < 4; t++) begin
      if (slice_cnt[t] > best && sleep_cnt[t] == 0 && !blocked[t]) begin
        best = slice_cnt[t];
        pick = t;
      end else if (sleep_cnt[t] > 0) begin
        sleep_cnt[t]--;
      end
    end
    return pick;
  endfunction

  // Full schedule; returns 1 when no task can ever be picked.
  function automatic bit schedule_tasks();
    int pick;
    logic [16:0] skip;
    pick = pass_once();
    if (pick >= 0) begin
      cur_task = pick[1:0];
      return 1'b0;
    end
    for (int t = 0; t < 4; t++) slice_cnt[t] = prio_reg[t];
    skip = SKIP_NONE;
    for (int t = 0; t < 4; t++)
      if (!blocked[t] && prio_reg[t] > 0 && {1'b0, sleep_cnt[t]} < skip)
        skip = {1'b0, sleep_cnt[t]};
    if (skip == SKIP_NONE) return 1'b1;
    // The idle passes are collapsed into a single subtraction of the
    // smallest sleep count among the tasks that could run.
    for (int t = 0; t < 4; t++)
      sleep_cnt[t] = ({1'b0, sleep_cnt[t]} > skip) ? sleep_cnt[t] - skip[15:0] : 16'd0;
    pick = pass_once();
    if (pick < 0) return 1'b1;
    cur_task = pick[1:0];
    return 1'b0;
  endfunction

  function automatic sched_result_t predict_word(logic [2:0] k, logic [15:0] amt, logic l);
    sched_result_t r;
    logic [1:0] t;
    r = '0;
    case (k)
      KIND_TICK: if (slice_cnt[cur_task] > 0) slice_cnt[cur_task]--;
      KIND_SCHED: r.none = schedule_tasks();
      KIND_SLEEP: begin
        sleep_cnt[cur_task] = amt;
        r.none = schedule_tasks();
      end
      KIND_P: begin
        if (lock_cnt[l] > -128) lock_cnt[l]--;
        if (lock_cnt[l] < 0) begin
          blocked[cur_task] = 1'b1;
          ring[{l, ring_head[l]}] = cur_task;
          ring_written[{l, ring_head[l]}] = 1'b1;
          ring_head[l]++;
          r.none = schedule_tasks();
        end
      end
      KIND_V: begin
        if (lock_cnt[l] < 127) lock_cnt[l]++;
        if (lock_cnt[l] <= 0) begin
          t = ring[{l, ring_tail[l]}];
          blocked[t] = 1'b0;
          r.woke = 1'b1;
          r.who = t;
          ring_tail[l]++;
        end
      end
      default: ;
    endcase
    r.run = cur_task;
    return r;
  endfunction

  // True when a V on this lock would wake from a ring slot never written.
  function automatic bit wake_unsafe(logic l);
    int c;
    c = (lock_cnt[l] < 127) ? lock_cnt[l] + 1 : lock_cnt[l];
    return c <= 0 && !ring_written[{l, ring_tail[l]}];
  endfunction

  // Idle gaps: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 50);
  endfunction

  // Sends one word; valid is lowered only when a gap precedes the next word,
  // so a back-to-back word never sees valid lowered and raised in one step.
  task automatic send_word(logic [2:0] k, logic [15:0] amt, logic l, bit known,
                           sched_result_t want);
    int gap;
    sched_result_t p;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= k;
    in_sleep_amount <= amt;
    in_lock_index   <= l;
    do @(posedge clk); while (!in_ready);
    p = predict_word(k, amt, l);
    expected_q.push_back(known ? want : p);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < REG_INIT0) begin
      prio_reg[idx[1:0]] = data;
    end else if (idx < REG_SPARE) begin
      init_reg[idx[0]] = data[3:0];
      lock_cnt[idx[0]] = data[3:0];
    end
    @(posedge clk);
  endtask

  // Registers may change only when the block holds nothing: wait for the
  // last result, then give the block its schedule latency on top.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic stim_row_t row(logic [2:0] k, logic [15:0] amt, logic l, bit known,
                                    sched_result_t want);
    stim_row_t r;
    r.kind = k;
    r.amount = amt;
    r.lock = l;
    r.known_result = known;
    r.want = want;
    return r;
  endfunction

  // Random word. Most words are lock traffic and scheduling so that tasks
  // block, wake and sleep; sleep amounts are usually small to keep sleepers
  // waking within a phase.
  task automatic random_word();
    logic [2:0]  k;
    logic [15:0] amt;
    logic        l;
    int          r;
    r = $urandom_range(99);
    l = 1'($urandom_range(1));
    amt = 16'($urandom_range(0, 6));
    if (r < 22) k = KIND_TICK;
    else if (r < 36) k = KIND_SCHED;
    else if (r < 50) begin
      k = KIND_SLEEP;
      if ($urandom_range(9) < 2) amt = 16'($urandom);
    end
    else if (r < 72) k = KIND_P;
    else if (r < 96) k = KIND_V;
    else k = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    if (!$urandom_range(15)) amt = 16'($urandom);
    if (k == KIND_V && wake_unsafe(l)) k = KIND_TICK;
    send_word(k, amt, l, 1'b0, '0);
  endtask

  // Result side: random stalls on out_ready and the in-order comparison.
  int stall = 0;
  always @(posedge clk) begin
    sched_result_t got, exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_running_task, out_none_ready, out_woke_valid, out_woken_task};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %p", got);
        end else begin
          exp_w = expected_q.pop_front();
          if (got.run !== exp_w.run || got.none !== exp_w.none ||
              got.woke !== exp_w.woke || got.who !== exp_w.who) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: running %0d/%0d none %0d/%0d woke %0d/%0d woken %0d/%0d",
                       exp_w.run, got.run, exp_w.none, got.none,
                       exp_w.woke, got.woke, exp_w.who, got.who);
          end
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        out_ready <= 1'b0;
      end else begin
        stall <= ($urandom_range(7) == 0) ? pick_gap() : 0;
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("task_scheduler_with_semaphores_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_kind         <= KIND_TICK;
    in_sleep_amount <= '0;
    in_lock_index   <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_PRIO0;
    cfg_data        <= '0;
    for (int t = 0; t < 4; t++) begin
      prio_reg[t] = 8'd1;
      slice_cnt[t] = '0;
      sleep_cnt[t] = '0;
      blocked[t] = 1'b0;
    end
    for (int i = 0; i < 2; i++) begin
      init_reg[i] = 4'd1;
      lock_cnt[i] = 1;
      ring_head[i] = '0;
      ring_tail[i] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      ring[i] = '0;
      ring_written[i] = 1'b0;
    end
    cur_task = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with reset register values. The hand-typed rows cover
    // the first word after reset, the ignored kinds, the first schedule (which
    // refills every slice and lands on task 0), a P that leaves the count at
    // zero, and the V that wakes task 0 after it blocked.
    table_rows.push_back(row(KIND_TICK, 16'd0, 1'b0, 1'b1, '{2'd0, 1'b0, 1'b0, 2'd0}));
    table_rows.push_back(row(KIND_UNUSED_LO, 16'hFFFF, 1'b1, 1'b1, '{2'd0, 1'b0, 1'b0, 2'd0}));
    table_rows.push_back(row(KIND_UNUSED_HI, 16'd0, 1'b0, 1'b1, '{2'd0, 1'b0, 1'b0, 2'd0}));
    table_rows.push_back(row(KIND_SCHED, 16'd0, 1'b0, 1'b1, '{2'd0, 1'b0, 1'b0, 2'd0}));
    table_rows.push_back(row(KIND_P, 16'd0, 1'b0, 1'b1, '{2'd0, 1'b0, 1'b0, 2'd0}));
    table_rows.push_back(row(KIND_P, 16'd0, 1'b0, 1'b0, '0));
    table_rows.push_back(row(KIND_V, 16'd0, 1'b0, 1'b1, '{2'd1, 1'b0, 1'b1, 2'd0}));
    table_rows.push_back(row(KIND_SLEEP, 16'hFFFF, 1'b0, 1'b0, '0));
    table_rows.push_back(row(KIND_SLEEP, 16'd0, 1'b0, 1'b0, '0));
    table_rows.push_back(row(KIND_TICK, 16'd0, 1'b0, 1'b0, '0));
    table_rows.push_back(row(KIND_TICK, 16'd0, 1'b0, 1'b0, '0));
    table_rows.push_back(row(KIND_P, 16'd0, 1'b1, 1'b0, '0));
    table_rows.push_back(row(KIND_P, 16'd0, 1'b1, 1'b0, '0));
    table_rows.push_back(row(KIND_P, 16'd0, 1'b1, 1'b0, '0));
    table_rows.push_back(row(KIND_V, 16'd0, 1'b1, 1'b0, '0));
    table_rows.push_back(row(KIND_V, 16'd0, 1'b1, 1'b0, '0));
    table_rows.push_back(row(KIND_SLEEP, 16'h5A5A, 1'b0, 1'b0, '0));
    table_rows.push_back(row(KIND_SCHED, 16'd0, 1'b0, 1'b0, '0));
    table_rows.push_back(row(KIND_V, 16'd0, 1'b0, 1'b0, '0));
    foreach (table_rows[i])
      send_word(table_rows[i].kind, table_rows[i].amount, table_rows[i].lock,
                table_rows[i].known_result, table_rows[i].want);

    // Random phases. The first two use the register extremes; the spare
    // indexes are written too and must be ignored. Every third phase
    // runs without idling on either side.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      calm = (ph % 3 == 2);
      for (int i = 0; i < 4; i++)
        write_reg(3'(REG_PRIO0 + i), 8'(ph == 0 ? 8'hFF :
                  ph == 1 ? (i == 3 ? 8'd1 : 8'd0) :
                  ($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 3))));
      for (int i = 0; i < 2; i++)
        write_reg(3'(REG_INIT0 + i), 8'(ph == 0 ? 8'hFF : ph == 1 ? 8'hF0 : $urandom));
      if (ph < 2) write_reg(3'(REG_SPARE + ph), 8'($urandom));
      repeat (ITEMS_PER_PHASE) random_word();
    end

    drain();
    if (errors == 0 && expected_q.size() == 0)
      $display("task_scheduler_with_semaphores_unit_tb: clean");
    else
      $display("task_scheduler_with_semaphores_unit_tb: errors");
    $finish;
  end

endmodule

[sim.f]
src/tsws_pkg.sv
src/task_scheduler_with_semaphores_unit.sv
tb/task_scheduler_with_semaphores_unit_tb.sv
